@@ rtl/core/sapa_pkg.sv @@
// Package for the subnet address pool allocator: payload structs, codes,
// map geometry constants and the map initialization helpers.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sapa_pkg;

  localparam int MAX_HOST_BITS = 8;
  localparam int ADDR_W        = 32;
  localparam int HB_W          = 4;
  localparam int COUNT_W       = 9;
  localparam int HOST_W        = MAX_HOST_BITS;
  localparam int N_W           = MAX_HOST_BITS + 1;
  localparam int MAP_DEPTH     = 1 << MAX_HOST_BITS;
  localparam int WORD_BITS     = (MAP_DEPTH < 32) ? MAP_DEPTH : 32;
  localparam int BIT_W         = $clog2(WORD_BITS);
  localparam int NUM_WORDS     = MAP_DEPTH / WORD_BITS;
  localparam int WORD_IDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int CFG_IDX_W     = 1;

  localparam logic [HB_W-1:0] HB_MIN   = HB_W'(3);
  localparam logic [HB_W-1:0] HB_MAX   = HB_W'(MAX_HOST_BITS);
  localparam logic [HB_W-1:0] HB_RESET = HB_W'(8);

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [1:0] {
    OP_ALLOC_LOWEST = 2'd0,
    OP_ALLOC_REQ    = 2'd1,
    OP_FREE         = 2'd2,
    OP_QUERY        = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OUTSIDE   = 2'd1,
    ST_EXHAUSTED = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NETWORK_PREFIX = 1'd0,
    REG_HOST_BITS      = 1'd1
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [ADDR_W-1:0] address;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [ADDR_W-1:0]  granted_address;
    logic [COUNT_W-1:0] free_count;
  } res_t;

  // controller -> datapath
  typedef struct packed {
    logic       load;
    logic       ptr_clr;
    logic       ptr_inc;
    logic       use_scan;
    logic       set_req;
    logic       clr_req;
    logic       set_scan;
    logic       finish;
    status_t    status;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_t  op;
    logic in_net;
    logic host_used;
    logic word_free;
    logic ptr_last;
  } dp_stat_t;

  // host bits saturated to the supported range
  function automatic logic [HB_W-1:0] eff_bits(input logic [HB_W-1:0] hb);
    logic [HB_W-1:0] e;
    e = hb;
    if (e < HB_MIN) e = HB_MIN;
    if (e > HB_MAX) e = HB_MAX;
    return e;
  endfunction

  // reset pattern of one map word: host 0, all-ones and all-ones minus one used
  function automatic word_t init_word(input logic [HB_W-1:0] eff,
                                      input logic [WORD_IDX_W-1:0] widx);
    word_t w;
    int    n;
    int    g;
    n = 1 << eff;
    for (int b = 0; b < WORD_BITS; b++) begin
      g = int'(widx) * WORD_BITS + b;
      w[b] = (g == 0) || (g == n - 1) || (g == n - 2);
    end
    return w;
  endfunction

endpackage

@@ rtl/core/sapa_ctrl.sv @@
// Controller of the subnet address pool allocator: sequences evaluate and
// word-by-word scan steps and issues datapath commands.
// Depends on sapa_pkg.
`timescale 1ns / 1ps

module sapa_ctrl
  import sapa_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy,
  output logic     done
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_SCAN
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    cmd.status = ST_OK;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        case (stat.op)
          OP_ALLOC_LOWEST: begin
            cmd.ptr_clr = 1'b1;
            state_next  = S_SCAN;
          end
          OP_ALLOC_REQ: begin
            if (!stat.in_net) begin
              cmd.status = ST_OUTSIDE;
              cmd.finish = 1'b1;
            end else if (!stat.host_used) begin
              cmd.set_req = 1'b1;
              cmd.finish  = 1'b1;
            end else begin
              // taken: fall back to lowest free host
              cmd.ptr_clr = 1'b1;
              state_next  = S_SCAN;
            end
          end
          OP_FREE: begin
            if (!stat.in_net) begin
              cmd.status = ST_OUTSIDE;
            end else begin
              cmd.clr_req = stat.host_used;
            end
            cmd.finish = 1'b1;
          end
          default: begin
            cmd.finish = 1'b1;
          end
        endcase
      end
      S_SCAN: begin
        cmd.use_scan = 1'b1;
        if (stat.word_free) begin
          cmd.set_scan = 1'b1;
          cmd.finish   = 1'b1;
        end else if (stat.ptr_last) begin
          cmd.status = ST_EXHAUSTED;
          cmd.finish = 1'b1;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (cmd.finish) state_next = S_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.finish;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

@@ rtl/core/sapa_datapath.sv @@
// Datapath of the subnet address pool allocator: configuration registers,
// used-bit map in words, scan pointer, free counter and result register.
// Depends on sapa_pkg.
`timescale 1ns / 1ps

module sapa_datapath
  import sapa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [ADDR_W-1:0]     cfg_data,
  input  req_t                  request,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  output res_t                  result
);

  logic [ADDR_W-1:0]     prefix;
  logic [HB_W-1:0]       hbits;
  word_t                 map [NUM_WORDS];
  logic [N_W-1:0]        free_total;
  logic [N_W-1:0]        free_total_next;
  logic [WORD_IDX_W-1:0] ptr;
  logic [1:0]            req_op;
  logic [ADDR_W-1:0]     req_addr;

  logic [HB_W-1:0]       eff;
  logic [HB_W-1:0]       eff_next;
  logic [N_W-1:0]        n_hosts;
  logic [ADDR_W-1:0]     mask;
  logic [ADDR_W-1:0]     base;
  logic [HOST_W-1:0]     req_host;
  logic [WORD_IDX_W-1:0] req_word;
  logic [BIT_W-1:0]      req_bit;
  logic [WORD_IDX_W-1:0] sel_idx;
  word_t                 sel_word;
  word_t                 free_bits;
  logic [BIT_W-1:0]      hit_bit;
  logic [HOST_W-1:0]     hit_host;
  logic                  reinit;

  assign eff      = eff_bits(hbits);
  assign n_hosts  = N_W'(1) << eff;
  assign mask     = (ADDR_W'(1) << eff) - ADDR_W'(1);
  assign base     = prefix & ~mask;
  assign req_host = HOST_W'(req_addr & mask);
  assign req_word = WORD_IDX_W'(req_host >> BIT_W);
  assign req_bit  = req_host[BIT_W-1:0];
  assign sel_idx  = cmd.use_scan ? ptr : req_word;
  assign sel_word = map[sel_idx];
  assign reinit   = rst || cfg_we;

  // width that the map is rebuilt for on reset or a register write
  always_comb begin
    eff_next = eff;
    if (rst) begin
      eff_next = eff_bits(HB_RESET);
    end else if (cfg_we && cfg_index == REG_HOST_BITS) begin
      eff_next = eff_bits(cfg_data[HB_W-1:0]);
    end
  end

  // free hosts of the scanned word, bits beyond the subnet masked off
  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      free_bits[b] = !sel_word[b] && ((int'(ptr) * WORD_BITS + b) < int'(n_hosts));
    end
    hit_bit = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (free_bits[b]) hit_bit = BIT_W'(b);
    end
  end

  assign hit_host = HOST_W'({ptr, hit_bit});

  always_comb begin
    free_total_next = free_total;
    if (cmd.set_req || cmd.set_scan) begin
      free_total_next = free_total - N_W'(1);
    end else if (cmd.clr_req) begin
      free_total_next = free_total + N_W'(1);
    end
  end

  assign stat.op        = op_t'(req_op);
  assign stat.in_net    = ((req_addr & ~mask) == base);
  assign stat.host_used = sel_word[req_bit];
  assign stat.word_free = |free_bits;
  assign stat.ptr_last  = (ptr == WORD_IDX_W'((n_hosts - N_W'(1)) >> BIT_W));

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix <= '0;
      hbits  <= HB_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NETWORK_PREFIX: prefix <= cfg_data;
        REG_HOST_BITS:      hbits  <= cfg_data[HB_W-1:0];
        default:            ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (reinit) begin
      for (int w = 0; w < NUM_WORDS; w++) begin
        map[w] <= init_word(eff_next, WORD_IDX_W'(w));
      end
      free_total <= (N_W'(1) << eff_next) - N_W'(3);
    end else begin
      if (cmd.set_req) begin
        map[req_word][req_bit] <= 1'b1;
      end else if (cmd.clr_req) begin
        map[req_word][req_bit] <= 1'b0;
      end else if (cmd.set_scan) begin
        map[ptr][hit_bit] <= 1'b1;
      end
      free_total <= free_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if (cmd.ptr_clr) begin
      ptr <= '0;
    end else if (cmd.ptr_inc) begin
      ptr <= ptr + WORD_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op   <= request.op;
      req_addr <= request.address;
    end
    if (cmd.finish) begin
      result.status     <= cmd.status;
      result.free_count <= COUNT_W'(free_total_next);
      if (cmd.set_req) begin
        result.granted_address <= req_addr;
      end else if (cmd.set_scan) begin
        result.granted_address <= base | ADDR_W'(hit_host);
      end else begin
        result.granted_address <= '0;
      end
    end
  end

endmodule

@@ rtl/core/subnet_address_pool_allocator.sv @@
// Subnet address pool allocator: one request per transfer against a used-bit
// map of the subnet's hosts. Instantiates sapa_ctrl and sapa_datapath.
// Depends on sapa_pkg.
//
// Usage:
//   Request channel: a transfer happens at a rising edge with start high and
//   busy low; request carries op and address. Result channel: done is high
//   for exactly one cycle with result (status, granted_address, free_count);
//   the receiver takes it in that cycle and cannot hold it off.
//   Query, free and a granted requested address finish in the evaluate
//   state; done is registered from that finish. Allocate-lowest, and a
//   requested address already taken, scan the map one 32-bit word per cycle
//   after the evaluate state, 1 to 8 words at eight host bits and 1 when
//   the subnet has 32 hosts or fewer; done is registered from the scan's end.
//   busy drops in the done cycle, so a new request may follow there; the
//   block takes no new request before the current one is done.
//   Configuration: cfg_we writes cfg_data into register cfg_index (0 network
//   prefix, 1 host bits) while idle; either write rebuilds the map at once.
//   Reset (rst, synchronous): prefix 0, eight host bits, hosts 0, 254 and
//   255 reserved, 253 free; the map is ready in the next cycle.
`timescale 1ns / 1ps

module subnet_address_pool_allocator
  import sapa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  req_t                 request,
  output logic                 done,
  output res_t                 result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sapa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  sapa_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .request   (request),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result)
  );

endmodule

@@ rtl/core/sapa_checker.sv @@
// Port-level checker for the subnet address pool allocator, bound to the top.
// Depends on sapa_pkg and subnet_address_pool_allocator.
`timescale 1ns / 1ps

module sapa_checker
  import sapa_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input res_t result
);

  // an accepted request keeps the block busy in the next cycle
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after request transfer");

  // a request passes the evaluate state before its result, so results never come back to back
  a_no_double_done: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe on two consecutive cycles");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a request in progress");

  a_fail_no_grant: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ST_OK) |-> (result.granted_address == '0))
    else $error("address granted on a failed request");

  a_status_count: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status != 2'd3 && result.free_count <= COUNT_W'(256)))
    else $error("bad status code or free count");

endmodule

bind subnet_address_pool_allocator sapa_checker u_sapa_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

@@ tb/sv/sapa_pool_checker.sv @@
// Result checker for the subnet address pool allocator: predicts every request
// transfer from its own copy of the used-bit map and compares each result.
// Depends on sapa_pkg; instantiated beside the block by the testbench top.
`timescale 1ns / 1ps

module sapa_pool_checker
  import sapa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  req_t                 request,
  input  logic                 done,
  input  res_t                 result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data,
  output int                   fail_count,
  output int                   outstanding
);

  logic [ADDR_W-1:0]    cfg_prefix;
  logic [HB_W-1:0]      cfg_host_bits;
  logic [MAP_DEPTH-1:0] used_map;
  logic [COUNT_W-1:0]   free_total;
  res_t                 expected_replies[$];
  int                   n_fail = 0;
  int                   n_wait = 0;

  assign fail_count  = n_fail;
  assign outstanding = n_wait;

  // host width saturated to 3..MAX_HOST_BITS
  function automatic logic [ADDR_W-1:0] host_mask();
    int w;
    w = int'(cfg_host_bits);
    if (w < 3) w = 3;
    if (w > MAX_HOST_BITS) w = MAX_HOST_BITS;
    return (32'd1 << w) - 32'd1;
  endfunction

  function automatic void rebuild_map();
    int n;
    n = int'(host_mask()) + 1;
    used_map = '0;
    used_map[0] = 1'b1;
    used_map[n-1] = 1'b1;
    used_map[n-2] = 1'b1;
    free_total = COUNT_W'(n - 3);
  endfunction

  function automatic res_t serve_request(input req_t r);
    res_t              o;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] base;
    logic [HOST_W-1:0] host;
    logic              in_net;
    logic              want_lowest;
    logic              found;
    int                n;
    mask = host_mask();
    base = cfg_prefix & ~mask;
    n = int'(mask) + 1;
    in_net = (r.address & ~mask) == base;
    host = HOST_W'(r.address & mask);
    o.status = ST_OK;
    o.granted_address = '0;
    want_lowest = 1'b0;
    found = 1'b0;
    case (r.op)
      OP_ALLOC_LOWEST: want_lowest = 1'b1;
      OP_ALLOC_REQ: begin
        if (!in_net) begin
          o.status = ST_OUTSIDE;
        end else if (!used_map[host]) begin
          used_map[host] = 1'b1;
          free_total = free_total - 1'b1;
          o.granted_address = r.address;
        end else begin
          want_lowest = 1'b1;  // taken: fall back to lowest free host
        end
      end
      OP_FREE: begin
        if (!in_net) begin
          o.status = ST_OUTSIDE;
        end else if (used_map[host]) begin
          used_map[host] = 1'b0;
          free_total = free_total + 1'b1;
        end
      end
      default: ;
    endcase
    if (want_lowest) begin
      for (int h = 0; h < n; h++) begin
        if (!found && !used_map[h]) begin
          found = 1'b1;
          used_map[h] = 1'b1;
          free_total = free_total - 1'b1;
          o.granted_address = base | ADDR_W'(h);
        end
      end
      if (!found) o.status = ST_EXHAUSTED;
    end
    o.free_count = free_total;
    return o;
  endfunction

  task automatic note_mismatch(input string what, input logic [ADDR_W-1:0] want,
                               input logic [ADDR_W-1:0] got);
    n_fail++;
    if (n_fail <= 10)
      $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      cfg_prefix = '0;
      cfg_host_bits = HB_RESET;
      rebuild_map();
      expected_replies.delete();
    end else begin
      // a result may retire in the same edge as the next request transfer
      if (done) begin
        if (expected_replies.size() == 0) begin
          note_mismatch("unrequested result", '0, result.granted_address);
        end else begin
          want = expected_replies.pop_front();
          if (result.status !== want.status)
            note_mismatch("status", want.status, result.status);
          if (result.granted_address !== want.granted_address)
            note_mismatch("granted_address", want.granted_address, result.granted_address);
          if (result.free_count !== want.free_count)
            note_mismatch("free_count", want.free_count, result.free_count);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_NETWORK_PREFIX: cfg_prefix = cfg_data;
          REG_HOST_BITS:      cfg_host_bits = cfg_data[HB_W-1:0];
          default: ;
        endcase
        rebuild_map();
      end
      if (start && !busy) expected_replies.push_back(serve_request(request));
    end
    n_wait = expected_replies.size();
  end

endmodule

@@ tb/sv/tb_subnet_address_pool_allocator.sv @@
// Testbench top for the subnet address pool allocator: clock, reset, directed
// and random request stimulus, register writes and the verdict.
// Depends on sapa_pkg, the block and sapa_pool_checker.
`timescale 1ns / 1ps

module tb_subnet_address_pool_allocator;
  import sapa_pkg::*;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  req_t                 request;
  logic                 done;
  res_t                 result;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ADDR_W-1:0]    cfg_data;
  int                   fail_count;
  int                   outstanding;

  logic [ADDR_W-1:0]    cur_prefix;
  logic [HB_W-1:0]      cur_host_bits;
  int                   n_sent;
  bit                   quiet;

  subnet_address_pool_allocator u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sapa_pool_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .request     (request),
    .done        (done),
    .result      (result),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #5000000;
    $display("tb_subnet_address_pool_allocator NOT OK");
    $finish;
  end

  // hold start until the transfer happens
  task automatic send_req(input op_t op, input logic [ADDR_W-1:0] addr);
    @(negedge clk);
    start = 1'b1;
    request.op = op;
    request.address = addr;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_sent++;
    quiet = (n_sent >= 1200);
  endtask

  task automatic sender_gap();
    int g;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      g = $urandom_range(1, 10);
      @(negedge clk);
      start = 1'b0;
      request = req_t'({$urandom, $urandom});
      repeat (g - 1) @(negedge clk);
    end
  endtask

  // writes only once every result is back
  task automatic write_reg(input reg_idx_t idx, input logic [ADDR_W-1:0] data);
    @(negedge clk);
    start = 1'b0;
    while (outstanding != 0) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    if (idx == REG_NETWORK_PREFIX) cur_prefix = data;
    else cur_host_bits = data[HB_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [ADDR_W-1:0] pick_address(input bit in_subnet);
    int                w;
    logic [ADDR_W-1:0] mask;
    w = int'(cur_host_bits);
    if (w < 3) w = 3;
    if (w > MAX_HOST_BITS) w = MAX_HOST_BITS;
    mask = (32'd1 << w) - 32'd1;
    if (in_subnet) return (cur_prefix & ~mask) | ($urandom & mask);
    return $urandom;
  endfunction

  task automatic random_phase(input int n_items);
    int                w_lowest;
    int                r;
    op_t               op;
    logic [ADDR_W-1:0] pfx;
    logic [ADDR_W-1:0] hb;
    case ($urandom_range(0, 3))
      0:       pfx = '0;
      1:       pfx = '1;
      default: pfx = $urandom;
    endcase
    hb = {$urandom_range(0, 1) ? 28'd0 : 28'($urandom), 4'($urandom_range(0, 15))};
    if ($urandom_range(0, 1)) hb[HB_W-1:0] = HB_W'($urandom_range(3, 5));
    if ($urandom_range(0, 1)) begin
      write_reg(REG_NETWORK_PREFIX, pfx);
      write_reg(REG_HOST_BITS, hb);
    end else begin
      write_reg(REG_HOST_BITS, hb);
      write_reg(REG_NETWORK_PREFIX, pfx);
    end
    w_lowest = $urandom_range(20, 70);
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      if (r < w_lowest) op = OP_ALLOC_LOWEST;
      else if (r < w_lowest + 20) op = OP_ALLOC_REQ;
      else if (r < 95) op = OP_FREE;
      else op = OP_QUERY;
      if (op == OP_ALLOC_REQ || op == OP_FREE)
        send_req(op, pick_address($urandom_range(0, 99) < 85));
      else
        send_req(op, $urandom);
      sender_gap();
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    cfg_we = 1'b0;
    cfg_index = REG_NETWORK_PREFIX;
    cfg_data = '0;
    cur_prefix = '0;
    cur_host_bits = HB_RESET;
    n_sent = 0;
    quiet = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset map: prefix 0, eight host bits
    send_req(OP_QUERY, 32'hA5A5_5A5A);
    send_req(OP_ALLOC_LOWEST, 32'hDEAD_BEEF);
    send_req(OP_ALLOC_REQ, 32'h0000_0080);
    sender_gap();
    send_req(OP_ALLOC_REQ, 32'h0000_0080);    // taken, falls back
    send_req(OP_ALLOC_REQ, 32'hFFFF_FF05);    // outside
    send_req(OP_FREE, 32'h1234_5678);         // outside
    send_req(OP_FREE, 32'h0000_0010);         // already free
    send_req(OP_FREE, 32'h0000_00FF);         // reserved host released
    send_req(OP_ALLOC_REQ, 32'h0000_00FF);
    send_req(OP_FREE, 32'h0000_0000);
    send_req(OP_ALLOC_LOWEST, 32'hFFFF_FFFF); // grants host 0
    send_req(OP_QUERY, 32'hFFFF_FFFF);

    // smallest subnet at the top of the address space
    write_reg(REG_HOST_BITS, 32'd3);
    write_reg(REG_NETWORK_PREFIX, 32'hFFFF_FFFF);
    repeat (5) send_req(OP_ALLOC_LOWEST, $urandom);
    send_req(OP_ALLOC_LOWEST, $urandom);      // exhausted
    send_req(OP_ALLOC_REQ, 32'hFFFF_FFF9);    // taken, no fallback left
    send_req(OP_ALLOC_REQ, 32'h0000_0001);
    send_req(OP_FREE, 32'hFFFF_FFFF);
    send_req(OP_ALLOC_LOWEST, $urandom);
    send_req(OP_QUERY, $urandom);

    // host bits saturate at both ends
    write_reg(REG_HOST_BITS, 32'hFFFF_FFF0);
    write_reg(REG_NETWORK_PREFIX, 32'hC0A8_0100);
    send_req(OP_ALLOC_REQ, 32'hC0A8_0106);    // reserved, falls back
    write_reg(REG_HOST_BITS, 32'h0000_000F);
    send_req(OP_ALLOC_REQ, 32'hC0A8_01FE);
    send_req(OP_QUERY, 32'h0);

    for (int p = 0; p < 12; p++) random_phase(110);

    @(negedge clk);
    start = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("tb_subnet_address_pool_allocator OK");
    else
      $display("tb_subnet_address_pool_allocator NOT OK");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/sapa_pkg.sv
rtl/core/sapa_ctrl.sv
rtl/core/sapa_datapath.sv
rtl/core/subnet_address_pool_allocator.sv
rtl/core/sapa_checker.sv
tb/sv/sapa_pool_checker.sv
tb/sv/tb_subnet_address_pool_allocator.sv
